// ===== hw/rtl/pmlh_pkg.sv =====
// Package for the split-field PML Hy update block.
// Holds the request and result types, default sizes and the saturation helper.
// No dependencies.
package pmlh_pkg;

    // Default storage depth and fraction width.
    localparam int DEF_PML_ENTRIES = 65536;
    localparam int DEF_FRAC_BITS   = 16;

    // The divider resolves 32 quotient bits, one per stage, after one set-up stage.
    localparam int DIV_STEPS = 32;
    localparam int DIV_LAT   = DIV_STEPS + 1;

    localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7fff_ffff;
    localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic        [15:0] entry_index;
        logic signed [31:0] ex_here;
        logic signed [31:0] ex_next_z;
        logic signed [31:0] ez_here;
        logic signed [31:0] ez_next_x;
        logic signed [31:0] z_metric;
        logic signed [31:0] x_metric;
        logic signed [31:0] h_scale;
        logic        [30:0] loss_scale;
        logic        [30:0] z_grading;
        logic        [30:0] x_grading;
    } pmlh_req_t;

    typedef struct packed {
        logic        [15:0] out_index;
        logic signed [31:0] hy_value;
    } pmlh_res_t;

    // Clamp a signed value to the 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
        begin
            r = 32'sh7fff_ffff;
        end
        else if (v < S32_MIN)
        begin
            r = -32'sh7fff_ffff - 32'sh1;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/pmlh_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pmlh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65536
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/pmlh_div_pipe.sv =====
// Pipelined signed fixed-point divider: (num * 2^FRAC_BITS) / den, truncated toward zero.
// Depends on pmlh_pkg for the stage count. The denominator is positive and at least
// 2^FRAC_BITS, so the quotient always fits in 32 bits.
module pmlh_div_pipe #(
    parameter int FRAC_BITS = pmlh_pkg::DEF_FRAC_BITS
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] num,
    input  logic        [30:0] den,
    output logic signed [31:0] quo
);
    import pmlh_pkg::*;

    localparam int DW = 32 + FRAC_BITS;

    // One entry per stage: partial remainder, dividend bits shifting out while
    // quotient bits shift in, the divisor and the result sign.
    logic [30:0] rem_reg  [DIV_LAT];
    logic [31:0] work_reg [DIV_LAT];
    logic [30:0] den_reg  [DIV_LAT];
    logic        neg_reg  [DIV_LAT];

    logic [31:0]   mag;
    logic [DW-1:0] dvd;
    logic [32:0]   q33;

    // Magnitude of the scaled dividend. Its top FRAC_BITS bits are below the
    // divisor, so they load straight into the remainder.
    always_comb
    begin
        mag = num[31] ? 32'(-33'(num)) : 32'(num);
        dvd = DW'(mag) << FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= 31'(dvd >> 32);
            work_reg[0] <= dvd[31:0];
            den_reg[0]  <= den;
            neg_reg[0]  <= num[31];
            for (int s = 1; s < DIV_LAT; s++)
            begin
                logic [31:0] rs;
                logic        ge;
                rs = {rem_reg[s-1], work_reg[s-1][31]};
                ge = rs >= {1'b0, den_reg[s-1]};
                rem_reg[s]  <= ge ? 31'(rs - {1'b0, den_reg[s-1]}) : rs[30:0];
                work_reg[s] <= {work_reg[s-1][30:0], ge};
                den_reg[s]  <= den_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
            end
        end
    end

    // Restore the sign of the quotient.
    always_comb
    begin
        q33 = {1'b0, work_reg[DIV_LAT-1]};
        quo = neg_reg[DIV_LAT-1] ? 32'(-q33) : 32'(q33);
    end

endmodule

// ===== hw/rtl/pml_split_field_h_update.sv =====
// Split-field PML update of one Hy cell. Each request names an entry and brings
// field samples and coefficients; the two split parts of that entry are read from
// an on-chip RAM, updated, divided by one plus the grading-loss product and written
// back, and their saturated sum is returned with the echoed index. One request is
// taken per cycle while req_stall is low. A result passes through four arithmetic
// stages, a 33-stage divider pipeline and the output register. A request whose
// entry is still in flight in those stages is held off until that entry has been
// written back, so a run of requests to one entry proceeds one request at a time.
// After reset the block clears the RAM, one entry per cycle, and takes no request
// until every entry has been cleared. Indices at or above PML_ENTRIES leave the
// RAM untouched and return a zero field value.
// Depends on pmlh_pkg, pmlh_ram and pmlh_div_pipe.
module pml_split_field_h_update #(
    parameter int PML_ENTRIES = pmlh_pkg::DEF_PML_ENTRIES,
    parameter int FRAC_BITS   = pmlh_pkg::DEF_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  pmlh_pkg::pmlh_req_t req,
    output logic                res_valid,
    input  logic                res_stall,
    output pmlh_pkg::pmlh_res_t res
);
    import pmlh_pkg::*;

    localparam int AW = PML_ENTRIES > 1 ? $clog2(PML_ENTRIES) : 1;

    // Control.
    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          out_free, adv, accept, hazard;

    // Stage A: differences and first products.
    logic               va_reg, inr_a_reg;
    logic        [15:0] idx_a_reg;
    logic signed [31:0] dex_a_reg, dez_a_reg;
    logic signed [63:0] rz_p_a_reg, rx_p_a_reg;
    logic        [61:0] gz_p_a_reg, gx_p_a_reg;

    // Stage B: scaled coefficients, denominators, stored parts.
    logic               vb_reg, inr_b_reg;
    logic        [15:0] idx_b_reg;
    logic signed [31:0] dex_b_reg, dez_b_reg, rz_b_reg, rx_b_reg, sz_b_reg, sx_b_reg;
    logic        [30:0] dz_b_reg, dx_b_reg;

    // Stage C: term products.
    logic               vc_reg, inr_c_reg;
    logic        [15:0] idx_c_reg;
    logic signed [63:0] tz_p_c_reg, tx_p_c_reg;
    logic signed [31:0] sz_c_reg, sx_c_reg;
    logic        [30:0] dz_c_reg, dx_c_reg;

    // Stage D: numerators.
    logic               vd_reg, inr_d_reg;
    logic        [15:0] idx_d_reg;
    logic signed [31:0] nz_d_reg, nx_d_reg;
    logic        [30:0] dz_d_reg, dx_d_reg;

    // Side data running alongside the divider.
    logic        dv_vld_reg [DIV_LAT];
    logic        dv_inr_reg [DIV_LAT];
    logic [15:0] dv_idx_reg [DIV_LAT];

    logic               res_valid_reg;
    pmlh_res_t          res_reg;

    logic        [63:0] rdata;
    logic signed [31:0] qz, qx;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [63:0]        wdata;
    logic               last_vld;

    logic signed [63:0] s_b_rz, s_b_rx;
    logic        [62:0] den_sz, den_sx;
    logic signed [31:0] tz_d, tx_d;

    assign last_vld = dv_vld_reg[DIV_LAT-1];
    assign out_free = !res_valid_reg || !res_stall;
    assign adv      = out_free || !last_vld;

    // Hold off a request whose entry is still being updated further down.
    always_comb
    begin
        hazard = (va_reg && idx_a_reg == req.entry_index)
              || (vb_reg && idx_b_reg == req.entry_index)
              || (vc_reg && idx_c_reg == req.entry_index)
              || (vd_reg && idx_d_reg == req.entry_index);
        for (int s = 0; s < DIV_LAT; s++)
        begin
            if (dv_vld_reg[s] && dv_idx_reg[s] == req.entry_index)
            begin
                hazard = 1'b1;
            end
        end
    end

    assign req_stall = clearing_reg || hazard || !adv;
    assign accept    = req_valid && !req_stall;

    // Clearing pass after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == AW'(PML_ENTRIES - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // Split-part store: z part in the upper half, x part in the lower half.
    assign we    = clearing_reg || (adv && last_vld && dv_inr_reg[DIV_LAT-1]);
    assign waddr = clearing_reg ? clr_addr_reg : AW'(dv_idx_reg[DIV_LAT-1]);
    assign wdata = clearing_reg ? 64'd0 : {qz, qx};

    pmlh_ram #(
        .WIDTH (64),
        .DEPTH (PML_ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (accept),
        .raddr (AW'(req.entry_index)),
        .rdata (rdata)
    );

    // Valid bits of the arithmetic stages and the divider side chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            for (int s = 0; s < DIV_LAT; s++)
            begin
                dv_vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            va_reg        <= accept;
            vb_reg        <= va_reg;
            vc_reg        <= vb_reg;
            vd_reg        <= vc_reg;
            dv_vld_reg[0] <= vd_reg;
            for (int s = 1; s < DIV_LAT; s++)
            begin
                dv_vld_reg[s] <= dv_vld_reg[s-1];
            end
        end
    end

    // Stage B and D combinational pieces.
    always_comb
    begin
        s_b_rz = rz_p_a_reg >>> FRAC_BITS;
        s_b_rx = rx_p_a_reg >>> FRAC_BITS;
        den_sz = 63'(gz_p_a_reg >> FRAC_BITS) + (63'(1) << FRAC_BITS);
        den_sx = 63'(gx_p_a_reg >> FRAC_BITS) + (63'(1) << FRAC_BITS);
        tz_d   = sat32(tz_p_c_reg >>> FRAC_BITS);
        tx_d   = sat32(tx_p_c_reg >>> FRAC_BITS);
    end

    // Arithmetic stage payloads.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Stage A.
            idx_a_reg  <= req.entry_index;
            inr_a_reg  <= 25'(req.entry_index) < 25'(PML_ENTRIES);
            dex_a_reg  <= sat32(64'(req.ex_next_z) - 64'(req.ex_here));
            dez_a_reg  <= sat32(64'(req.ez_next_x) - 64'(req.ez_here));
            rz_p_a_reg <= 64'(req.z_metric) * 64'(req.h_scale);
            rx_p_a_reg <= 64'(req.x_metric) * 64'(req.h_scale);
            gz_p_a_reg <= 62'(req.z_grading) * 62'(req.loss_scale);
            gx_p_a_reg <= 62'(req.x_grading) * 62'(req.loss_scale);
            // Stage B.
            idx_b_reg  <= idx_a_reg;
            inr_b_reg  <= inr_a_reg;
            dex_b_reg  <= dex_a_reg;
            dez_b_reg  <= dez_a_reg;
            rz_b_reg   <= sat32(s_b_rz);
            rx_b_reg   <= sat32(s_b_rx);
            dz_b_reg   <= den_sz > 63'h7fff_ffff ? 31'h7fff_ffff : den_sz[30:0];
            dx_b_reg   <= den_sx > 63'h7fff_ffff ? 31'h7fff_ffff : den_sx[30:0];
            sz_b_reg   <= rdata[63:32];
            sx_b_reg   <= rdata[31:0];
            // Stage C.
            idx_c_reg  <= idx_b_reg;
            inr_c_reg  <= inr_b_reg;
            tz_p_c_reg <= 64'(rz_b_reg) * 64'(dex_b_reg);
            tx_p_c_reg <= 64'(rx_b_reg) * 64'(dez_b_reg);
            sz_c_reg   <= sz_b_reg;
            sx_c_reg   <= sx_b_reg;
            dz_c_reg   <= dz_b_reg;
            dx_c_reg   <= dx_b_reg;
            // Stage D.
            idx_d_reg  <= idx_c_reg;
            inr_d_reg  <= inr_c_reg;
            nz_d_reg   <= sat32(64'(sz_c_reg) - 64'(tz_d));
            nx_d_reg   <= sat32(64'(sx_c_reg) + 64'(tx_d));
            dz_d_reg   <= dz_c_reg;
            dx_d_reg   <= dx_c_reg;
            // Side data alongside the divider.
            dv_idx_reg[0] <= idx_d_reg;
            dv_inr_reg[0] <= inr_d_reg;
            for (int s = 1; s < DIV_LAT; s++)
            begin
                dv_idx_reg[s] <= dv_idx_reg[s-1];
                dv_inr_reg[s] <= dv_inr_reg[s-1];
            end
        end
    end

    // Division of each part by its denominator.
    pmlh_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_z (
        .clk (clk),
        .en  (adv),
        .num (nz_d_reg),
        .den (dz_d_reg),
        .quo (qz)
    );

    pmlh_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_x (
        .clk (clk),
        .en  (adv),
        .num (nx_d_reg),
        .den (dx_d_reg),
        .quo (qx)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= last_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            res_reg.out_index <= dv_idx_reg[DIV_LAT-1];
            res_reg.hy_value  <= dv_inr_reg[DIV_LAT-1] ? sat32(64'(qz) + 64'(qx)) : 32'sd0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
